/* rtl/ordered_array_list_engine_defines.svh */
// Assertion macros shared by the checker of the ordered array list engine.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define OAL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define OAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/oal_pkg.sv */
// Package for the ordered array list engine: field widths, operation and
// status codes, cell commands and controller states. No dependencies.
`timescale 1ns / 1ps

package oal_pkg;

    localparam int KIND_W    = 3;
    localparam int POS_W     = 11;
    localparam int IDX_OUT_W = 10;
    localparam int CNT_OUT_W = 11;
    localparam int STAT_W    = 3;

    // Requested operation
    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 3'd0,
        KIND_LOCATE = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    // Result status
    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_BADPOS = 3'd2,
        STAT_EMPTY  = 3'd3,
        STAT_MISS   = 3'd4
    } t_status;

    // Command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_GET,
        CELL_LOCATE
    } t_cell_op;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_RESULT
    } t_state;

endpackage

/* rtl/oal_cell.sv */
// One storage cell of the list row: holds one entry, shifts with its
// neighbors on insert/delete and flags a hit for get/locate. Uses oal_pkg.
`timescale 1ns / 1ps

module oal_cell #(
    parameter int CNT_W      = 11,
    parameter int DATA_WIDTH = 8,
    parameter int INDEX      = 0
) (
    input  logic                   i_clk,
    input  oal_pkg::t_cell_op      i_op,
    input  logic [CNT_W-1:0]       i_pos,
    input  logic [CNT_W-1:0]       i_lim,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic [DATA_WIDTH-1:0]  i_prev_data,
    input  logic [DATA_WIDTH-1:0]  i_next_data,
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic                   o_hit
);

    import oal_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Shift in from the lower neighbor on insert, from the upper on delete
    always_comb begin
        n_data = r_data;
        case (i_op)
            CELL_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_value;
                end else if (MY_IDX > i_pos) begin
                    n_data = i_prev_data;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= i_pos) begin
                    n_data = i_next_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Hit: addressed by get, or live entry equal to the searched value
    always_comb begin
        case (i_op)
            CELL_GET:    o_hit = (MY_IDX == i_pos);
            CELL_LOCATE: o_hit = (MY_IDX < i_lim) && (r_data == i_value);
            default:     o_hit = 1'b0;
        endcase
    end

    assign o_data = r_data;

endmodule

/* rtl/oal_tree.sv */
// Registered priority tree over the cell hits: returns the lowest hit index
// and its entry, one tree level per cycle. Standalone, no package needed.
`timescale 1ns / 1ps

module oal_tree #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_hit  [CAPACITY],
    input  logic [DATA_WIDTH-1:0]                    i_data [CAPACITY],
    output logic                                     o_hit,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] o_index,
    output logic [DATA_WIDTH-1:0]                    o_data
);

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LVLS  = $clog2(CAPACITY);
    localparam int LEAVES = 1 << LVLS;
    localparam int NODES = 2 * LEAVES - 1;

    // Heap layout: node n has children 2n+1 (lower indexes) and 2n+2
    logic                  r_hit [NODES];
    logic [IW-1:0]         r_idx [NODES];
    logic [DATA_WIDTH-1:0] r_dat [NODES];

    // Leaf row, captured from the cells
    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k < CAPACITY) begin : g_live
            always_ff @(posedge i_clk) begin
                r_hit[LEAVES-1+k] <= i_hit[k];
                r_idx[LEAVES-1+k] <= IW'(k);
                r_dat[LEAVES-1+k] <= i_data[k];
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_hit[LEAVES-1+k] <= 1'b0;
                r_idx[LEAVES-1+k] <= '0;
                r_dat[LEAVES-1+k] <= '0;
            end
        end
    end

    // Inner nodes: the lower child wins when it has a hit
    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
        always_ff @(posedge i_clk) begin
            r_hit[n] <= r_hit[2*n+1] | r_hit[2*n+2];
            r_idx[n] <= r_hit[2*n+1] ? r_idx[2*n+1] : r_idx[2*n+2];
            r_dat[n] <= r_hit[2*n+1] ? r_dat[2*n+1] : r_dat[2*n+2];
        end
    end

    assign o_hit   = r_hit[0];
    assign o_index = r_idx[0];
    assign o_data  = r_dat[0];

endmodule

/* rtl/ordered_array_list_engine.sv */
// Flow: an accepted item passes through S_EXEC and S_RESULT; get and locate also wait in
// S_SEARCH while the registered priority tree over the cell row (one level per cycle)
// settles. The result beat is registered from S_RESULT once the output is free, and no
// new item is taken until then.
// Reset (synchronous, active low) empties the list and clears the handshake;
// stored entries are not cleared.
`timescale 1ns / 1ps

module ordered_array_list_engine #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [oal_pkg::KIND_W-1:0]     i_kind,
    input  logic [oal_pkg::POS_W-1:0]      i_position,
    input  logic [DATA_WIDTH-1:0]          i_value,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [oal_pkg::STAT_W-1:0]     o_status,
    output logic [DATA_WIDTH-1:0]          o_read_value,
    output logic [oal_pkg::IDX_OUT_W-1:0]  o_found_index,
    output logic [oal_pkg::CNT_OUT_W-1:0]  o_count,
    output logic                           o_is_empty
);

    import oal_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = (CW > POS_W) ? CW : POS_W;
    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LVLS = $clog2(CAPACITY);
    localparam int WW   = (LVLS > 0) ? $clog2(LVLS + 1) : 1;

    // Control state
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [WW-1:0]        r_wait;
    logic                 r_out_valid;

    // Held item and pending result
    logic [KIND_W-1:0]    r_kind;
    logic [POS_W-1:0]     r_pos;
    logic [DATA_WIDTH-1:0] r_value;
    logic [STAT_W-1:0]    r_res_status;
    logic [DATA_WIDTH-1:0] r_res_rd;
    logic [IW-1:0]        r_res_idx;

    // Output payload
    logic [STAT_W-1:0]    r_out_status;
    logic [DATA_WIDTH-1:0] r_out_rd;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [CNT_OUT_W-1:0] r_out_count;
    logic                 r_out_empty;

    // Decode of the held item
    t_cell_op             e_op;
    logic [STAT_W-1:0]    e_status;
    logic                 e_search;
    logic [PW-1:0]        w_pos_x;
    logic [PW-1:0]        w_cnt_x;

    // Row and tree wiring
    t_cell_op             w_cell_op;
    logic [CW-1:0]        w_cell_pos;
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_prev [CAPACITY];
    logic [DATA_WIDTH-1:0] w_next [CAPACITY];
    logic                 w_hit  [CAPACITY];
    logic                 w_root_hit;
    logic [IW-1:0]        w_root_idx;
    logic [DATA_WIDTH-1:0] w_root_data;

    logic                 w_in_beat;
    logic                 w_out_free;
    logic                 w_tree_done;
    logic [STAT_W-1:0]    s_status;
    logic [DATA_WIDTH-1:0] s_rd;
    logic [IW-1:0]        s_idx;

    assign w_pos_x = PW'(r_pos);
    assign w_cnt_x = PW'(r_count);

    // Range checks, cell command and next count for the held item
    always_comb begin
        e_op     = CELL_HOLD;
        e_status = STAT_OK;
        e_search = 1'b0;
        n_count  = r_count;
        unique case (r_kind)
            KIND_GET: begin
                if ((w_pos_x == '0) || (w_pos_x > w_cnt_x)) begin
                    e_status = STAT_BADPOS;
                end else begin
                    e_op     = CELL_GET;
                    e_search = 1'b1;
                end
            end
            KIND_LOCATE: begin
                e_op     = CELL_LOCATE;
                e_search = 1'b1;
            end
            KIND_INSERT: begin
                if (w_cnt_x >= PW'(CAPACITY)) begin
                    e_status = STAT_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    e_status = STAT_BADPOS;
                end else begin
                    e_op    = CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            KIND_DELETE: begin
                if (r_count == '0) begin
                    e_status = STAT_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    e_status = STAT_BADPOS;
                end else begin
                    e_op    = CELL_DELETE;
                    n_count = r_count - 1'b1;
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: ;
        endcase
    end

    assign w_in_beat   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_tree_done = (r_state == S_SEARCH) && (r_wait == WW'(LVLS));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_beat) n_state = S_EXEC;
            S_EXEC:   n_state = e_search ? S_SEARCH : S_RESULT;
            S_SEARCH: if (w_tree_done) n_state = S_RESULT;
            S_RESULT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_cell_op  = (r_state == S_EXEC) ? e_op : CELL_HOLD;
    end

    // Get addresses entry pos-1; insert/delete use pos as is
    assign w_cell_pos = (r_kind == KIND_GET) ? CW'(w_pos_x - 1'b1) : CW'(r_pos);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count <= n_count;
            end
            r_wait <= (r_state == S_SEARCH) ? r_wait + 1'b1 : '0;
            if ((r_state == S_RESULT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result of a finished search
    always_comb begin
        s_status = STAT_OK;
        s_rd     = '0;
        s_idx    = '0;
        if (r_kind == KIND_GET) begin
            s_rd = w_root_data;
        end else if (w_root_hit) begin
            s_idx = w_root_idx;
        end else begin
            s_status = STAT_MISS;
        end
    end

    // Item capture, pending result and output payload
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_value <= i_value;
        end
        if ((r_state == S_EXEC) && !e_search) begin
            r_res_status <= e_status;
            r_res_rd     <= '0;
            r_res_idx    <= '0;
        end else if (w_tree_done) begin
            r_res_status <= s_status;
            r_res_rd     <= s_rd;
            r_res_idx    <= s_idx;
        end
        if ((r_state == S_RESULT) && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_rd     <= r_res_rd;
            r_out_idx    <= IDX_OUT_W'(r_res_idx);
            r_out_count  <= CNT_OUT_W'(r_count);
            r_out_empty  <= (r_count == '0);
        end
    end

    // Row of cells, each wired to its neighbors (zero at the row ends)
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign w_prev[k] = '0;
        end else begin : g_mid_lo
            assign w_prev[k] = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_next[k] = '0;
        end else begin : g_mid_hi
            assign w_next[k] = w_data[k+1];
        end

        oal_cell #(
            .CNT_W      (CW),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_cell_op),
            .i_pos       (w_cell_pos),
            .i_lim       (r_count),
            .i_value     (r_value),
            .i_prev_data (w_prev[k]),
            .i_next_data (w_next[k]),
            .o_data      (w_data[k]),
            .o_hit       (w_hit[k])
        );
    end

    oal_tree #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_hit   (w_hit),
        .i_data  (w_data),
        .o_hit   (w_root_hit),
        .o_index (w_root_idx),
        .o_data  (w_root_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = r_out_rd;
    assign o_found_index = r_out_idx;
    assign o_count       = r_out_count;
    assign o_is_empty    = r_out_empty;

endmodule

/* rtl/oal_chk.sv */
// Port-level checker for the ordered array list engine, bound to the top level.
// Uses oal_pkg and the assertion macros of ordered_array_list_engine_defines.svh.
`timescale 1ns / 1ps
`include "ordered_array_list_engine_defines.svh"

module oal_chk #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [oal_pkg::STAT_W-1:0]     o_status,
    input  logic [DATA_WIDTH-1:0]          o_read_value,
    input  logic [oal_pkg::IDX_OUT_W-1:0]  o_found_index,
    input  logic [oal_pkg::CNT_OUT_W-1:0]  o_count,
    input  logic                           o_is_empty
);

    import oal_pkg::*;

    // A stalled result beat stays and keeps its status, data, index and count
    `OAL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result beat dropped under stall")
    `OAL_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_status) && $stable(o_read_value) && $stable(o_found_index) && $stable(o_count), "stalled result changed")

    // One item in flight: an input beat closes the input side behind it
    `OAL_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall, "input taken while busy")

    // Empty flag agrees with the reported length
    `OAL_ASSERT_SAME(a_empty_flag, o_out_valid, o_is_empty == (o_count == '0), "empty flag mismatch")

    // A failed operation reports neither data nor index
    `OAL_ASSERT_SAME(a_err_clean, o_out_valid && (o_status != STAT_OK), (o_read_value == '0) && (o_found_index == '0), "error result carries data")

endmodule

bind ordered_array_list_engine oal_chk #(.DATA_WIDTH(DATA_WIDTH)) u_oal_chk (.*);

/* sim/testbench.sv */
// Self-checking testbench for ordered_array_list_engine: a scoreboard class
// mirrors the list, and tasks drive get/locate/insert/delete/clear requests.
// Depends on oal_pkg and the engine RTL only.
`timescale 1ns / 1ps

module testbench;
    import oal_pkg::*;

    localparam int CAPACITY       = 1024;
    localparam int DATA_W         = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 30;
    localparam int MIXED_ITEMS    = 48;

    // Kind codes the engine treats as no-ops
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    typedef struct packed {
        t_status                status;
        logic [DATA_W-1:0]      read_value;
        logic [IDX_OUT_W-1:0]   found_index;
        logic [CNT_OUT_W-1:0]   count;
        logic                   is_empty;
    } t_list_result;

    // Shadow copy of the list plus the queue of results still owed
    class list_scoreboard;
        logic [DATA_W-1:0] shadow_entries [CAPACITY];
        int                shadow_len;
        int                peak_len;
        t_list_result      pending_results [$];
        int                errors;
        int                checked;
        int                status_seen [5];

        function new();
            shadow_len = 0;
            peak_len   = 0;
            errors     = 0;
            checked    = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        // Apply one accepted request to the shadow list and queue its result
        function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] val);
            t_list_result r;
            int j;
            r = '0;
            r.status = STAT_OK;
            case (kind)
                KIND_GET: begin
                    if (pos < 1 || int'(pos) > shadow_len) r.status = STAT_BADPOS;
                    else r.read_value = shadow_entries[int'(pos) - 1];
                end
                KIND_LOCATE: begin
                    r.status = STAT_MISS;
                    for (j = 0; j < shadow_len; j++) begin
                        if (shadow_entries[j] == val) begin
                            r.status = STAT_OK;
                            r.found_index = j[IDX_OUT_W-1:0];
                            break;
                        end
                    end
                end
                KIND_INSERT: begin
                    if (shadow_len >= CAPACITY) begin
                        r.status = STAT_FULL;
                    end else if (int'(pos) > shadow_len) begin
                        r.status = STAT_BADPOS;
                    end else begin
                        for (j = shadow_len; j > int'(pos); j--)
                            shadow_entries[j] = shadow_entries[j-1];
                        shadow_entries[int'(pos)] = val;
                        shadow_len++;
                    end
                end
                KIND_DELETE: begin
                    if (shadow_len == 0) begin
                        r.status = STAT_EMPTY;
                    end else if (int'(pos) >= shadow_len) begin
                        r.status = STAT_BADPOS;
                    end else begin
                        for (j = int'(pos); j + 1 < shadow_len; j++)
                            shadow_entries[j] = shadow_entries[j+1];
                        shadow_len--;
                    end
                end
                KIND_CLEAR: shadow_len = 0;
                default: ;
            endcase
            if (shadow_len > peak_len) peak_len = shadow_len;
            r.count    = shadow_len[CNT_OUT_W-1:0];
            r.is_empty = (shadow_len == 0);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, name, want, got);
            end
        endfunction

        // Compare one result beat against the oldest expectation
        function void check_result(t_list_result got);
            t_list_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with nothing expected, status %0d count %0d",
                         $time, got.status, got.count);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (int'(want.status) < 5) status_seen[int'(want.status)]++;
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("read_value", 16'(want.read_value), 16'(got.read_value));
            compare_field("found_index", 16'(want.found_index), 16'(got.found_index));
            compare_field("count", 16'(want.count), 16'(got.count));
            compare_field("is_empty", 16'(want.is_empty), 16'(got.is_empty));
        endfunction

        // A value currently in the list, so that locates mostly hit
        function logic [DATA_W-1:0] any_stored();
            if (shadow_len == 0) return DATA_W'($urandom_range(0, 255));
            return shadow_entries[$urandom_range(0, shadow_len - 1)];
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [KIND_W-1:0]     i_kind;
    logic [POS_W-1:0]      i_position;
    logic [DATA_W-1:0]     i_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [STAT_W-1:0]     o_status;
    logic [DATA_W-1:0]     o_read_value;
    logic [IDX_OUT_W-1:0]  o_found_index;
    logic [CNT_OUT_W-1:0]  o_count;
    logic                  o_is_empty;

    list_scoreboard board;
    int             burst_left;
    int             items_sent;
    int             idle_cycles;
    bit             hold_request;

    ordered_array_list_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_found_index (o_found_index),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Receiver: stall modes of random span, plus one long hold on request
    initial begin
        int mode;
        int span_left;
        int hold_left;
        int tick;
        bit hold_taken;
        mode        = 0;
        span_left   = 0;
        hold_left   = 0;
        tick        = 0;
        hold_taken  = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (span_left == 0) begin
                mode      = $urandom_range(0, 2);
                span_left = $urandom_range(20, 150);
            end
            span_left--;
            tick++;
            if (hold_left > 0)  i_out_stall <= 1'b1;
            else if (mode == 0) i_out_stall <= 1'b0;
            else if (mode == 1) i_out_stall <= 1'($urandom_range(0, 1));
            else                i_out_stall <= (tick % 4 != 0);
        end
    end

    // Result monitor and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_out_valid && !i_out_stall)
                board.check_result('{t_status'(o_status), o_read_value, o_found_index,
                                     o_count, o_is_empty});
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles at %0t ns", WATCHDOG_LIMIT, $time);
                $display("FAIL ordered_array_list_engine");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offer one request in bursts with random gaps; return once it is accepted
    task automatic send_item(input logic [KIND_W-1:0] kind, input int pos, input int val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_position <= POS_W'(pos);
        i_value    <= DATA_W'(val);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(kind, POS_W'(pos), DATA_W'(val));
        items_sent++;
    endtask

    // Sender pause until every expected result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (board.pending_results.size() > 0) @(posedge i_clk);
    endtask

    // One request of random kind, mostly well formed
    task automatic mixed_request();
        int r;
        int len;
        int pos;
        r   = $urandom_range(0, 99);
        len = board.shadow_len;
        if (r < 40) begin
            if (len < CAPACITY && $urandom_range(0, 9) != 0) pos = $urandom_range(0, len);
            else if (len < CAPACITY) pos = $urandom_range(len + 1, CAPACITY);
            else pos = $urandom_range(0, CAPACITY);
            send_item(KIND_INSERT, pos, $urandom_range(0, 255));
        end else if (r < 62) begin
            if (len > 0 && $urandom_range(0, 6) != 0) pos = $urandom_range(0, len - 1);
            else pos = $urandom_range(len, CAPACITY);
            send_item(KIND_DELETE, pos, $urandom_range(0, 255));
        end else if (r < 78) begin
            if (len > 0 && $urandom_range(0, 6) != 0) pos = $urandom_range(1, len);
            else if ($urandom_range(0, 1) == 0 || len >= CAPACITY) pos = 0;
            else pos = $urandom_range(len + 1, CAPACITY);
            send_item(KIND_GET, pos, $urandom_range(0, 255));
        end else if (r < 95) begin
            send_item(KIND_LOCATE, $urandom_range(0, CAPACITY),
                      ($urandom_range(0, 3) != 0) ? board.any_stored() : $urandom_range(0, 255));
        end else if (r < 97) begin
            send_item(KIND_CLEAR, $urandom_range(0, CAPACITY), $urandom_range(0, 255));
        end else begin
            send_item(KIND_UNUSED_LO
                      + KIND_W'($urandom_range(0, KIND_UNUSED_HI - KIND_UNUSED_LO)),
                      $urandom_range(0, CAPACITY), $urandom_range(0, 255));
        end
    endtask

    initial begin
        int r;
        int len;
        board        = new();
        burst_left   = 0;
        items_sent   = 0;
        hold_request = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_GET;
        i_position   = '0;
        i_value      = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list errors, edges of position and value, duplicates
        send_item(KIND_GET, 0, 0);
        send_item(KIND_GET, 1, 0);
        send_item(KIND_LOCATE, 0, 8'h00);
        send_item(KIND_DELETE, 0, 0);
        send_item(KIND_DELETE, CAPACITY, 0);
        send_item(KIND_INSERT, 1, 8'h11);
        send_item(KIND_INSERT, CAPACITY, 8'h22);
        send_item(KIND_INSERT, 0, 8'h00);
        send_item(KIND_INSERT, 1, 8'hFF);
        send_item(KIND_INSERT, 1, 8'h5A);
        send_item(KIND_INSERT, 0, 8'h5A);
        send_item(KIND_LOCATE, 0, 8'h5A);
        send_item(KIND_LOCATE, 0, 8'hFF);
        send_item(KIND_LOCATE, 0, 8'h33);
        send_item(KIND_GET, 1, 0);
        send_item(KIND_GET, 4, 0);
        send_item(KIND_GET, 5, 0);
        send_item(KIND_DELETE, 4, 0);
        send_item(KIND_DELETE, 3, 0);
        send_item(KIND_DELETE, 0, 0);
        send_item(KIND_UNUSED_LO, 0, 0);
        send_item(KIND_UNUSED_LO + 3'd1, 7, 8'hAA);
        send_item(KIND_UNUSED_HI, 2047 & CAPACITY, 8'h55);
        send_item(KIND_CLEAR, 0, 0);
        send_item(KIND_GET, 1, 0);
        send_item(KIND_DELETE, 0, 0);
        drain_results();

        // Random mix on a short list; receiver holds off so the engine backs up
        hold_request = 1'b1;
        repeat (MIXED_ITEMS) mixed_request();

        // Fill to capacity with values below 8'hFF, interleaving reads
        send_item(KIND_CLEAR, $urandom_range(0, CAPACITY), $urandom_range(0, 255));
        while (board.shadow_len < CAPACITY) begin
            r   = $urandom_range(0, 99);
            len = board.shadow_len;
            if (r < 95)      send_item(KIND_INSERT, $urandom_range(0, len), $urandom_range(0, 254));
            else if (r < 97) send_item(KIND_GET, $urandom_range(1, (len > 0) ? len : 1), 0);
            else             send_item(KIND_LOCATE, 0, board.any_stored());
        end

        // Full list: full takes priority over position, top index reachable
        send_item(KIND_INSERT, 0, 8'h01);
        send_item(KIND_INSERT, CAPACITY, 8'h02);
        send_item(KIND_GET, CAPACITY, 0);
        send_item(KIND_GET, 0, 0);
        send_item(KIND_DELETE, CAPACITY, 0);
        send_item(KIND_LOCATE, 0, board.any_stored());
        send_item(KIND_DELETE, CAPACITY - 1, 0);
        send_item(KIND_INSERT, CAPACITY - 1, 8'hFF);
        send_item(KIND_LOCATE, 0, 8'hFF);
        send_item(KIND_GET, CAPACITY, 0);
        send_item(KIND_DELETE, 0, 0);
        send_item(KIND_INSERT, CAPACITY, 8'h80);
        send_item(KIND_INSERT, CAPACITY - 1, 8'h7F);
        send_item(KIND_INSERT, 0, 8'h7F);
        send_item(KIND_CLEAR, CAPACITY, 8'hFF);
        send_item(KIND_GET, 1, 0);
        send_item(KIND_LOCATE, 0, 8'h7F);
        drain_results();

        // Closing random mix from an empty list
        repeat (MIXED_ITEMS / 2) mixed_request();

        // Wait out the tail, then report
        i_in_valid <= 1'b0;
        while (board.pending_results.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests and %0d result beats; list peaked at %0d of %0d entries.",
                 items_sent, board.checked, board.peak_len, CAPACITY);
        $display("Statuses ok/full/badpos/empty/miss: %0d/%0d/%0d/%0d/%0d",
                 board.status_seen[0], board.status_seen[1], board.status_seen[2],
                 board.status_seen[3], board.status_seen[4]);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("PASS ordered_array_list_engine");
        end else begin
            $display("FAIL ordered_array_list_engine");
        end
        $finish;
    end

endmodule
